// File: rtl/core/file_index_entry_builder_assert.svh
// ----------------------------------------------------------------------------
// file index entry builder assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef FILE_INDEX_ENTRY_BUILDER_ASSERT_SVH
`define FILE_INDEX_ENTRY_BUILDER_ASSERT_SVH

// checked on every rising edge outside reset
`define FIEB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define FIEB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/fieb_pkg.sv
// ----------------------------------------------------------------------------
// fieb_pkg
// types and constants of the file index entry builder
// ----------------------------------------------------------------------------
package fieb_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;
    typedef logic [25:0] fsize_t;
    typedef logic [18:0] burst_t;
    typedef logic [14:0] tindex_t;
    typedef logic [63:0] word_t;

    // register map, one register every four bytes
    typedef enum logic
    {
        REG_CRC_POLY = 1'b0,
        REG_CRC_INIT = 1'b1
    } reg_index_t;

    localparam int    APB_ADDR_W    = 3;
    localparam int    APB_DATA_W    = 32;
    localparam crc_t  CRC_POLY_RST  = 16'h1021;
    localparam crc_t  CRC_INIT_RST  = 16'hFFFF;

endpackage

// File: rtl/core/fieb_if.sv
// ----------------------------------------------------------------------------
// fieb channel interfaces
// valid/ready channels for name bytes in and index entries out
// ----------------------------------------------------------------------------
interface fieb_in_if;
    import fieb_pkg::*;

    logic   valid;
    logic   ready;
    byte_t  name_byte;
    logic   last_byte;
    fsize_t file_bytes;

    modport source (output valid, output name_byte, output last_byte,
                    output file_bytes, input ready);
    modport sink   (input valid, input name_byte, input last_byte,
                    input file_bytes, output ready);
endinterface

interface fieb_out_if;
    import fieb_pkg::*;

    logic    valid;
    logic    ready;
    logic    table_select;
    tindex_t table_index;
    word_t   entry_word;
    crc_t    name_crc;

    modport source (output valid, output table_select, output table_index,
                    output entry_word, output name_crc, input ready);
    modport sink   (input valid, input table_select, input table_index,
                    input entry_word, input name_crc, output ready);
endinterface

// File: rtl/core/fieb_crc_byte.sv
// ----------------------------------------------------------------------------
// fieb_crc_byte
// one byte of an msb-first crc-16 with programmable polynomial
// ----------------------------------------------------------------------------
module fieb_crc_byte
(
    input  fieb_pkg::crc_t  crc_in,
    input  fieb_pkg::byte_t data_in,
    input  fieb_pkg::crc_t  poly,
    output fieb_pkg::crc_t  crc_out
);
    import fieb_pkg::*;

    always_comb
    begin
        crc_t  crc;
        byte_t data;
        logic  fb;
        crc  = crc_in;
        data = data_in;
        for (int k = 0; k < 8; k++)
        begin
            fb   = crc[15] ^ data[7];
            crc  = {crc[14:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ poly;
            end
            data = {data[6:0], 1'b0};
        end
        crc_out = crc;
    end

endmodule

// File: rtl/core/file_index_entry_builder.sv
// ----------------------------------------------------------------------------
// file_index_entry_builder
// crc-16 hash index and packed, byte-reversed index entry per file name
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  in_chan   in   valid/ready         name_byte, last_byte, file_bytes
//  out_chan  out  valid/ready         table_select, table_index, entry_word,
//                                     name_crc
//  apb       in   psel/penable/pready crc_polynomial @0x0, crc_initial @0x4
//
//  one name byte a cycle sustained unless a stalled result holds bytes back;
//  a name's result passes input register, crc/burst stage and result reg
//  the rate is set by the byte-wide crc loop through the crc register
//  reset clears every valid flag, the burst address, the running crc and the
//  configuration registers
//  a stalled result holds in the result register while bytes that carry no
//  result keep flowing; bytes stop once a last byte waits behind it and the
//  input register is full
//
module file_index_entry_builder
(
    input  logic                           clk,
    input  logic                           rst_n,
    fieb_in_if.sink                        in_chan,
    fieb_out_if.source                     out_chan,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fieb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fieb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fieb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import fieb_pkg::*;

    // ceil(n / 192) = ((n + 191) >> 6) / 3, the divide by 3 by reciprocal
    localparam logic [7:0]  BURST_ROUND = 8'd191;
    localparam logic [19:0] RECIP_3     = 20'd699051;   // ceil(2^21 / 3)

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    crc_t       crc_poly_reg;
    crc_t       crc_init_reg;
    logic       cfg_wr;
    reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg <= CRC_POLY_RST;
            crc_init_reg <= CRC_INIT_RST;
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == REG_CRC_POLY)
            begin
                crc_poly_reg <= pwdata[15:0];
            end
            else
            begin
                crc_init_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_CRC_POLY: prdata = {16'b0, crc_poly_reg};
            REG_CRC_INIT: prdata = {16'b0, crc_init_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: each stage moves on when the next one has room
    // ------------------------------------------------------------------
    logic   a_valid_reg;
    byte_t  a_byte_reg;
    logic   a_last_reg;
    fsize_t a_size_reg;

    logic   b_valid_reg;
    logic   b_last_reg;
    crc_t   b_crc_reg;
    burst_t b_bursts_reg;
    fsize_t b_size_reg;

    logic   c_valid_reg;
    crc_t   c_crc_reg;
    word_t  c_entry_reg;

    logic   c_free;
    logic   b_adv;
    logic   a_adv;
    logic   c_load;

    assign c_free = !c_valid_reg || out_chan.ready;
    // a byte that is not the last of its name leaves no result behind
    assign b_adv  = b_valid_reg && (!b_last_reg || c_free);
    assign a_adv  = a_valid_reg && (!b_valid_reg || b_adv);
    assign c_load = b_adv && b_last_reg;

    assign in_chan.ready = !a_valid_reg || a_adv;

    // ------------------------------------------------------------------
    // stage a: input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_chan.ready)
        begin
            a_valid_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            a_byte_reg <= in_chan.name_byte;
            a_last_reg <= in_chan.last_byte;
            a_size_reg <= in_chan.file_bytes;
        end
    end

    // ------------------------------------------------------------------
    // stage b: crc update and burst count
    // ------------------------------------------------------------------
    crc_t        crc_reg;
    crc_t        crc_next;
    logic [26:0] size_round;
    logic [20:0] size_div64;
    logic [40:0] div_prod;
    burst_t      bursts;

    fieb_crc_byte u_crc_byte
    (
        .crc_in  (crc_reg),
        .data_in (a_byte_reg),
        .poly    (crc_poly_reg),
        .crc_out (crc_next)
    );

    assign size_round = {1'b0, a_size_reg} + {19'b0, BURST_ROUND};
    assign size_div64 = size_round[26:6];
    assign div_prod   = {20'b0, size_div64} * {21'b0, RECIP_3};
    assign bursts     = div_prod[39:21];

    // the crc restarts after the last byte of a name, or on a new initial
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT_RST;
        end
        else if (cfg_wr && cfg_idx == REG_CRC_INIT)
        begin
            crc_reg <= pwdata[15:0];
        end
        else if (a_adv)
        begin
            crc_reg <= a_last_reg ? crc_init_reg : crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!b_valid_reg || b_adv)
        begin
            b_valid_reg <= a_adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_last_reg   <= a_last_reg;
            b_crc_reg    <= crc_next;
            b_bursts_reg <= bursts;
            b_size_reg   <= a_size_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage c: entry packing, burst address advance, result register
    // ------------------------------------------------------------------
    burst_t next_burst_reg;
    burst_t next_burst_next;

    assign next_burst_next = next_burst_reg + b_bursts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_burst_reg <= '0;
        end
        else if (c_load)
        begin
            next_burst_reg <= next_burst_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= c_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_crc_reg   <= b_crc_reg;
            c_entry_reg <= {next_burst_reg, b_bursts_reg, b_size_reg};
        end
    end

    // entry goes out byte-reversed, byte 0 swapping with byte 7
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            out_chan.entry_word[8*k +: 8] = c_entry_reg[8*(7-k) +: 8];
        end
    end

    assign out_chan.valid        = c_valid_reg;
    assign out_chan.table_select = c_crc_reg[15];
    assign out_chan.table_index  = c_crc_reg[14:0];
    assign out_chan.name_crc     = c_crc_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `include "file_index_entry_builder_assert.svh"

    `FIEB_ASSERT(a_burst_hold, !c_load |=> $stable(next_burst_reg),
        "burst address moved without a result")
    `FIEB_ASSERT(a_start_field, c_load |=> c_entry_reg[63:45] == $past(next_burst_reg),
        "start burst is not the address before the advance")
    `FIEB_ASSERT(a_crc_reload,
        (a_adv && a_last_reg && !cfg_wr) |=> crc_reg == $past(crc_init_reg),
        "crc not reloaded after last byte")
    `FIEB_ASSERT(a_burst_ceil, (b_valid_reg && b_last_reg) |->
        (({9'b0, b_bursts_reg} * 28'd192 >= {2'b0, b_size_reg}) &&
         ({9'b0, b_bursts_reg} * 28'd192 < {2'b0, b_size_reg} + 28'd192)),
        "burst count is not the ceiling of size over 192")
    `FIEB_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_chan.valid,
        "result valid during reset")

endmodule
